[src/motor_homing_position_guard_assert.svh]
`ifndef MOTOR_HOMING_POSITION_GUARD_ASSERT_SVH
`define MOTOR_HOMING_POSITION_GUARD_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MHPG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MHPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mhpg_pkg.sv]
package mhpg_pkg;

    localparam int SETTLE_TICKS_DEF = 5;
    localparam int POS_WIDTH_DEF    = 32;

    localparam int DATA_W     = 32;
    localparam int TDATA_W    = 104;
    localparam int TUSER_W    = 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int DEADBAND_W = 16;
    localparam int LIMIT_W    = 20;
    localparam int THRESH_W   = 17;
    localparam int GAIN_W     = 20;
    localparam int RPM_CFG_W  = 18;
    localparam int COUNT_W    = 8;

    localparam logic signed [RPM_CFG_W-1:0] SEEK_RPM_RST    = -18'sd2500;
    localparam logic signed [RPM_CFG_W-1:0] BACKOFF_RPM_RST = -18'sd2300;
    localparam logic [COUNT_W-1:0]          BACKOFF_TICKS_RST = 8'd25;
    localparam logic [GAIN_W-1:0]           RPM_GAIN_RST    = 20'd100000;
    localparam logic [THRESH_W-1:0]         SPEED_THRESH_RST = 17'd500;
    localparam logic [DEADBAND_W-1:0]       DEADBAND_RST    = 16'd10;
    localparam logic [LIMIT_W-1:0]          STUCK_LIMIT_RST = 20'd200;
    localparam logic [LIMIT_W-1:0]          LOW_LIMIT_RST   = 20'd50;

    localparam logic [DATA_W-1:0] PREV_A_RST = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] PREV_B_RST = 32'hFFFF_FFFE;

    typedef enum logic [3:0] {
        MODE_SEEK    = 4'b0001,
        MODE_BACKOFF = 4'b0010,
        MODE_SETTLE  = 4'b0100,
        MODE_RUN     = 4'b1000
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEEK_RPM     = 3'd0,
        REG_BACKOFF_RPM  = 3'd1,
        REG_BACKOFF_TICK = 3'd2,
        REG_RPM_GAIN     = 3'd3,
        REG_SPEED_THRESH = 3'd4,
        REG_DEADBAND     = 3'd5,
        REG_STUCK_LIMIT  = 3'd6,
        REG_LOW_LIMIT    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [RPM_CFG_W-1:0] seek_rpm;
        logic signed [RPM_CFG_W-1:0] backoff_rpm;
        logic [COUNT_W-1:0]          backoff_ticks;
        logic [GAIN_W-1:0]           rpm_gain;
        logic [THRESH_W-1:0]         speed_threshold;
        logic [DEADBAND_W-1:0]       step_deadband;
        logic [LIMIT_W-1:0]          stuck_limit;
        logic [LIMIT_W-1:0]          low_limit;
    } cfg_t;

    typedef struct packed {
        logic              limit_open;
        logic [DATA_W-1:0] motor_rpm;
        logic [DATA_W-1:0] tach_count;
        logic              velocity_valid;
        logic [DATA_W-1:0] velocity_q16;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] rpm_command;
        logic              send_command;
        logic              homing_active;
        logic [DATA_W-1:0] position_out;
        logic              stuck_flag;
        logic [DATA_W-1:0] velocity_feedback;
    } res_t;

endpackage

[src/mhpg_cfg.sv]
module mhpg_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mhpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mhpg_pkg::CFG_DATA_W-1:0]   cfg_data,
    output mhpg_pkg::cfg_t                    cfg
);

    mhpg_pkg::cfg_t cfg_reg;
    mhpg_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (mhpg_pkg::cfg_idx_t'(cfg_index))
                mhpg_pkg::REG_SEEK_RPM:
                    cfg_next.seek_rpm = cfg_data[mhpg_pkg::RPM_CFG_W-1:0];
                mhpg_pkg::REG_BACKOFF_RPM:
                    cfg_next.backoff_rpm = cfg_data[mhpg_pkg::RPM_CFG_W-1:0];
                mhpg_pkg::REG_BACKOFF_TICK:
                    cfg_next.backoff_ticks = cfg_data[mhpg_pkg::COUNT_W-1:0];
                mhpg_pkg::REG_RPM_GAIN:
                    cfg_next.rpm_gain = cfg_data[mhpg_pkg::GAIN_W-1:0];
                mhpg_pkg::REG_SPEED_THRESH:
                    cfg_next.speed_threshold = cfg_data[mhpg_pkg::THRESH_W-1:0];
                mhpg_pkg::REG_DEADBAND:
                    cfg_next.step_deadband = cfg_data[mhpg_pkg::DEADBAND_W-1:0];
                mhpg_pkg::REG_STUCK_LIMIT:
                    cfg_next.stuck_limit = cfg_data[mhpg_pkg::LIMIT_W-1:0];
                mhpg_pkg::REG_LOW_LIMIT:
                    cfg_next.low_limit = cfg_data[mhpg_pkg::LIMIT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seek_rpm        <= mhpg_pkg::SEEK_RPM_RST;
            cfg_reg.backoff_rpm     <= mhpg_pkg::BACKOFF_RPM_RST;
            cfg_reg.backoff_ticks   <= mhpg_pkg::BACKOFF_TICKS_RST;
            cfg_reg.rpm_gain        <= mhpg_pkg::RPM_GAIN_RST;
            cfg_reg.speed_threshold <= mhpg_pkg::SPEED_THRESH_RST;
            cfg_reg.step_deadband   <= mhpg_pkg::DEADBAND_RST;
            cfg_reg.stuck_limit     <= mhpg_pkg::STUCK_LIMIT_RST;
            cfg_reg.low_limit       <= mhpg_pkg::LOW_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[src/mhpg_vel.sv]
module mhpg_vel (
    input  logic [mhpg_pkg::DATA_W-1:0]  held_velocity,
    input  logic [mhpg_pkg::GAIN_W-1:0]  rpm_gain,
    output logic [mhpg_pkg::DATA_W-1:0]  velocity_cmd
);

    localparam int PROD_W = mhpg_pkg::DATA_W + mhpg_pkg::GAIN_W;
    localparam int SHR_W  = PROD_W - 16;

    logic                        neg;
    logic [mhpg_pkg::DATA_W-1:0] vmag;
    logic [PROD_W-1:0]           prod;
    logic [SHR_W-1:0]            p;
    logic [SHR_W-1:0]            p_neg;

    // Q16.16 times integer gain; magnitude is shifted so the result truncates toward zero
    always_comb
    begin
        neg   = held_velocity[mhpg_pkg::DATA_W-1];
        vmag  = neg ? (mhpg_pkg::DATA_W'(0) - held_velocity) : held_velocity;
        prod  = PROD_W'(vmag) * PROD_W'(rpm_gain);
        p     = prod[PROD_W-1:16];
        p_neg = SHR_W'(0) - p;
        if (neg)
        begin
            if (p >= SHR_W'(33'h0_8000_0000))
                velocity_cmd = 32'h8000_0000;
            else
                velocity_cmd = p_neg[mhpg_pkg::DATA_W-1:0];
        end
        else
        begin
            if (p > SHR_W'(33'h0_7FFF_FFFF))
                velocity_cmd = 32'h7FFF_FFFF;
            else
                velocity_cmd = p[mhpg_pkg::DATA_W-1:0];
        end
    end

endmodule

[src/mhpg_core.sv]
module mhpg_core #(
    parameter int SETTLE_TICKS = mhpg_pkg::SETTLE_TICKS_DEF,
    parameter int POS_WIDTH    = mhpg_pkg::POS_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_vld,
    input  mhpg_pkg::in_item_t   item,
    input  mhpg_pkg::cfg_t       cfg,
    input  logic                 m_ready,
    output logic                 adv,
    output logic                 m_vld,
    output mhpg_pkg::res_t       res
);

    localparam int TIMER_W = (SETTLE_TICKS > 1) ? $clog2(SETTLE_TICKS) : 1;
    localparam int PW      = POS_WIDTH;
    localparam int DW      = POS_WIDTH + 1;
    localparam int MAG_W   = (POS_WIDTH > mhpg_pkg::LIMIT_W) ? POS_WIDTH : mhpg_pkg::LIMIT_W;
    localparam int DATA_W  = mhpg_pkg::DATA_W;

    mhpg_pkg::mode_t mode_reg, mode_next;
    logic [mhpg_pkg::COUNT_W-1:0] bc_reg, bc_next;
    logic [TIMER_W-1:0]           timer_reg, timer_next;
    logic [DATA_W-1:0]            prev_a_reg, prev_a_next;
    logic [DATA_W-1:0]            prev_b_reg, prev_b_next;
    logic [DATA_W-1:0]            origin_reg, origin_next;
    logic [PW-1:0]                acc_reg, acc_next;
    logic [PW-1:0]                cur_reg, cur_next;
    logic [PW-1:0]                hist1_reg, hist1_next;
    logic [PW-1:0]                hist2_reg, hist2_next;
    logic                         range_reg, range_next;
    logic                         homed_reg, homed_next;
    logic [DATA_W-1:0]            held_reg, held_next;
    logic                         out_vld_reg, out_vld_next;
    mhpg_pkg::res_t               res_reg, res_next;

    logic              fire;
    logic [DATA_W-1:0] vel_cmd;
    logic [DATA_W-1:0] rpm_mag;
    logic [DATA_W-1:0] pos_diff;
    logic [PW-1:0]     np;
    logic [DW-1:0]     step;
    logic [DW-1:0]     step_mag;
    logic [PW-1:0]     acc_u, cur_u, hist1_u, hist2_u;
    logic [PW-1:0]     cmag;
    logic              over, under, range_u, rehome;
    logic [DATA_W-1:0] cmd;
    logic              send, homing, stuck;

    assign adv   = !out_vld_reg || m_ready;
    assign fire  = item_vld && adv;
    assign m_vld = out_vld_reg;
    assign res   = res_reg;

    assign held_next = item.velocity_valid ? item.velocity_q16 : held_reg;

    mhpg_vel u_vel (
        .held_velocity (held_next),
        .rpm_gain      (cfg.rpm_gain),
        .velocity_cmd  (vel_cmd)
    );

    // run-mode position tracking, evaluated every cycle and used only in run
    always_comb
    begin
        rpm_mag  = item.motor_rpm[DATA_W-1] ? (DATA_W'(0) - item.motor_rpm) : item.motor_rpm;
        pos_diff = item.tach_count - origin_reg;
        np       = pos_diff[PW-1:0];
        step     = DW'($signed(np)) - DW'($signed(acc_reg));
        step_mag = step[DW-1] ? (DW'(0) - step) : step;

        acc_u   = acc_reg;
        cur_u   = cur_reg;
        hist1_u = hist1_reg;
        hist2_u = hist2_reg;
        if (rpm_mag > DATA_W'(cfg.speed_threshold))
        begin
            if (step_mag > DW'(cfg.step_deadband))
            begin
                hist2_u = hist1_reg;
                hist1_u = acc_reg;
                cur_u   = np;
                acc_u   = np;
            end
        end
        else
        begin
            hist2_u = hist1_reg;
            hist1_u = cur_reg;
        end

        cmag    = cur_u[PW-1] ? (PW'(0) - cur_u) : cur_u;
        over    = MAG_W'(cmag) > MAG_W'(cfg.stuck_limit);
        under   = MAG_W'(cmag) < MAG_W'(cfg.low_limit);
        range_u = range_reg || over;
        rehome  = homed_reg && range_u && (over || under)
                  && (cur_u == hist1_u) && (cur_u == hist2_u);
    end

    always_comb
    begin
        mode_next   = mode_reg;
        bc_next     = bc_reg;
        timer_next  = timer_reg;
        prev_a_next = prev_a_reg;
        prev_b_next = prev_b_reg;
        origin_next = origin_reg;
        acc_next    = acc_reg;
        cur_next    = cur_reg;
        hist1_next  = hist1_reg;
        hist2_next  = hist2_reg;
        range_next  = range_reg;
        homed_next  = homed_reg;
        cmd         = '0;
        send        = 1'b0;
        homing      = 1'b1;
        stuck       = 1'b0;

        case (mode_reg)
            mhpg_pkg::MODE_SEEK:
            begin
                send = 1'b1;
                if (item.limit_open)
                begin
                    cmd = DATA_W'(cfg.seek_rpm);
                end
                else
                begin
                    bc_next   = '0;
                    mode_next = mhpg_pkg::MODE_BACKOFF;
                end
            end
            mhpg_pkg::MODE_BACKOFF:
            begin
                send = 1'b1;
                if (bc_reg < cfg.backoff_ticks)
                begin
                    cmd     = DATA_W'(cfg.backoff_rpm);
                    bc_next = bc_reg + 1'b1;
                end
                else
                begin
                    timer_next  = '0;
                    prev_a_next = mhpg_pkg::PREV_A_RST;
                    prev_b_next = mhpg_pkg::PREV_B_RST;
                    mode_next   = mhpg_pkg::MODE_SETTLE;
                end
            end
            mhpg_pkg::MODE_SETTLE:
            begin
                if (timer_reg != '0)
                begin
                    timer_next = timer_reg - 1'b1;
                end
                else if ((item.tach_count == prev_a_reg) && (prev_a_reg == prev_b_reg))
                begin
                    // three equal samples: this one is the origin
                    origin_next = item.tach_count;
                    acc_next    = '0;
                    cur_next    = '0;
                    hist1_next  = '0;
                    hist2_next  = '0;
                    range_next  = 1'b0;
                    homed_next  = 1'b1;
                    mode_next   = mhpg_pkg::MODE_RUN;
                    cmd         = vel_cmd;
                    send        = 1'b1;
                end
                else
                begin
                    prev_b_next = prev_a_reg;
                    prev_a_next = item.tach_count;
                    timer_next  = TIMER_W'(SETTLE_TICKS - 1);
                end
            end
            mhpg_pkg::MODE_RUN:
            begin
                acc_next   = acc_u;
                cur_next   = cur_u;
                hist1_next = hist1_u;
                hist2_next = hist2_u;
                range_next = range_u;
                if (rehome)
                begin
                    bc_next   = '0;
                    mode_next = mhpg_pkg::MODE_SEEK;
                end
                else
                begin
                    homing = 1'b0;
                    stuck  = over;
                    if (!over)
                    begin
                        cmd  = vel_cmd;
                        send = 1'b1;
                    end
                end
            end
            default:
            begin
                mode_next = mhpg_pkg::MODE_SEEK;
            end
        endcase
    end

    always_comb
    begin
        res_next.rpm_command       = cmd;
        res_next.send_command      = send;
        res_next.homing_active     = homing;
        res_next.position_out      = DATA_W'($signed(cur_next));
        res_next.stuck_flag        = stuck;
        res_next.velocity_feedback = vel_cmd;
        out_vld_next = fire || (out_vld_reg && !m_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= mhpg_pkg::MODE_SEEK;
            bc_reg      <= '0;
            timer_reg   <= '0;
            prev_a_reg  <= mhpg_pkg::PREV_A_RST;
            prev_b_reg  <= mhpg_pkg::PREV_B_RST;
            origin_reg  <= '0;
            acc_reg     <= '0;
            cur_reg     <= '0;
            hist1_reg   <= '0;
            hist2_reg   <= '0;
            range_reg   <= 1'b0;
            homed_reg   <= 1'b0;
            held_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            if (fire)
            begin
                mode_reg   <= mode_next;
                bc_reg     <= bc_next;
                timer_reg  <= timer_next;
                prev_a_reg <= prev_a_next;
                prev_b_reg <= prev_b_next;
                origin_reg <= origin_next;
                acc_reg    <= acc_next;
                cur_reg    <= cur_next;
                hist1_reg  <= hist1_next;
                hist2_reg  <= hist2_next;
                range_reg  <= range_next;
                homed_reg  <= homed_next;
                held_reg   <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule

[src/motor_homing_position_guard.sv]
// Motor homing and position guard. Each transaction on the s_ side is one control tick and
// yields exactly one result transaction on the m_ side. A tick is taken every clock cycle
// unless m_tready holds back a result; it is captured in the input register and its result
// in the output register, with a stall possible in between. Homing state, position
// tracking and the velocity command (one 32x20 multiply with saturation) are all evaluated
// in the single combinational pass between those two registers. Configuration writes on
// cfg_* are always taken and should be issued only while no tick is in flight.
module motor_homing_position_guard #(
    parameter int SETTLE_TICKS = mhpg_pkg::SETTLE_TICKS_DEF,
    parameter int POS_WIDTH    = mhpg_pkg::POS_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [0] limit_open, [32:1] motor_rpm, [64:33] tach_count, [96:65] velocity_q16
    input  logic [mhpg_pkg::TDATA_W-1:0]      s_tdata,
    // [0] velocity_valid
    input  logic [mhpg_pkg::TUSER_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] rpm_command, [32] homing_active, [64:33] position_out, [65] stuck_flag,
    // [97:66] velocity_feedback
    output logic [mhpg_pkg::TDATA_W-1:0]      m_tdata,
    // [0] send_command
    output logic [mhpg_pkg::TUSER_W-1:0]      m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mhpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mhpg_pkg::CFG_DATA_W-1:0]   cfg_data
);

    mhpg_pkg::cfg_t     cfg;
    mhpg_pkg::in_item_t s_item;
    mhpg_pkg::in_item_t item_reg;
    mhpg_pkg::res_t     res;
    logic               in_vld_reg, in_vld_next;
    logic               adv;
    logic               s_take;

    assign s_item.limit_open     = s_tdata[0];
    assign s_item.motor_rpm      = s_tdata[32:1];
    assign s_item.tach_count     = s_tdata[64:33];
    assign s_item.velocity_q16   = s_tdata[96:65];
    assign s_item.velocity_valid = s_tuser[0];

    assign s_tready    = !in_vld_reg || adv;
    assign s_take      = s_tvalid && s_tready;
    assign in_vld_next = s_take || (in_vld_reg && !adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            item_reg <= s_item;
        end
    end

    mhpg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mhpg_core #(
        .SETTLE_TICKS (SETTLE_TICKS),
        .POS_WIDTH    (POS_WIDTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_vld (in_vld_reg),
        .item     (item_reg),
        .cfg      (cfg),
        .m_ready  (m_tready),
        .adv      (adv),
        .m_vld    (m_tvalid),
        .res      (res)
    );

    assign m_tdata = {6'b0, res.velocity_feedback, res.stuck_flag, res.position_out,
                      res.homing_active, res.rpm_command};
    assign m_tuser = res.send_command;

endmodule

[src/mhpg_chk.sv]
`include "motor_homing_position_guard_assert.svh"

module mhpg_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mhpg_pkg::TDATA_W-1:0]  m_tdata,
    input logic [mhpg_pkg::TUSER_W-1:0]  m_tuser
);

    `MHPG_ASSERT_NOW(a_stuck_no_send, m_tvalid && m_tdata[65], !m_tuser[0], "command sent while stuck")
    `MHPG_ASSERT_NOW(a_stuck_not_homing, m_tvalid && m_tdata[65], !m_tdata[32], "stuck flagged during homing")
    `MHPG_ASSERT_NOW(a_idle_cmd_zero, m_tvalid && !m_tuser[0], m_tdata[31:0] == 32'd0, "rpm nonzero with no command")
    `MHPG_ASSERT_NOW(a_run_cmd_is_vel, m_tvalid && m_tuser[0] && !m_tdata[32], m_tdata[31:0] == m_tdata[97:66], "run command differs from feedback")
    `MHPG_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind motor_homing_position_guard mhpg_chk u_mhpg_chk (.*);

[verif/tb_motor_homing_position_guard.sv]
module tb_motor_homing_position_guard;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SETTLE_TICKS = mhpg_pkg::SETTLE_TICKS_DEF;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          HOLD_CYCLES  = 80;
    localparam logic [31:0] INT_MAX32    = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN32    = 32'h8000_0000;
    localparam logic [31:0] HOME_TACH    = 32'h1234_5678;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    // [0] limit_open, [32:1] motor_rpm, [64:33] tach_count, [96:65] velocity_q16
    logic [mhpg_pkg::TDATA_W-1:0]    s_tdata;
    // [0] velocity_valid
    logic [mhpg_pkg::TUSER_W-1:0]    s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    // [31:0] rpm_command, [32] homing_active, [64:33] position_out, [65] stuck_flag,
    // [97:66] velocity_feedback
    logic [mhpg_pkg::TDATA_W-1:0]    m_tdata;
    // [0] send_command
    logic [mhpg_pkg::TUSER_W-1:0]    m_tuser;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [mhpg_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mhpg_pkg::CFG_DATA_W-1:0] cfg_data;

    motor_homing_position_guard DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    typedef struct {
        bit                   is_reg;
        mhpg_pkg::cfg_idx_t   idx;
        logic [19:0]          value;
        mhpg_pkg::in_item_t   tick;
        bit                   typed;
        mhpg_pkg::res_t       want;
    } plan_row_t;

    // shadow of the guard: registers and state
    mhpg_pkg::cfg_t     shadow = '{mhpg_pkg::SEEK_RPM_RST, mhpg_pkg::BACKOFF_RPM_RST,
                                   mhpg_pkg::BACKOFF_TICKS_RST, mhpg_pkg::RPM_GAIN_RST,
                                   mhpg_pkg::SPEED_THRESH_RST, mhpg_pkg::DEADBAND_RST,
                                   mhpg_pkg::STUCK_LIMIT_RST, mhpg_pkg::LOW_LIMIT_RST};
    mhpg_pkg::mode_t    g_mode        = mhpg_pkg::MODE_SEEK;
    logic [7:0]         g_backoff_cnt = '0;
    logic [2:0]         g_settle_tmr  = '0;
    logic signed [31:0] g_prev_a      = -32'sd1;
    logic signed [31:0] g_prev_b      = -32'sd2;
    logic signed [31:0] g_origin      = '0;
    logic signed [31:0] g_accepted    = '0;
    logic signed [31:0] g_pos         = '0;
    logic signed [31:0] g_hist1       = '0;
    logic signed [31:0] g_hist2       = '0;
    logic signed [31:0] g_held_vel    = '0;
    bit                 g_range       = 1'b0;
    bit                 g_homed       = 1'b0;

    mhpg_pkg::res_t     outputs_due[$];
    plan_row_t          plan[$];
    logic [31:0]        settle_target = HOME_TACH;
    int                 fault_count   = 0;
    int                 result_count  = 0;
    int                 cycle_count   = 0;
    bit                 quiet         = 1'b0;
    bit                 hold_req      = 1'b0;

    function automatic longint mag64(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    // Q16.16 request times integer gain, truncated toward zero, saturated to int32
    function automatic logic [31:0] rpm_from_velocity();
        longint v;
        longint p;
        v = g_held_vel;
        p = (mag64(v) * longint'(shadow.rpm_gain)) >>> 16;
        if (v < 0)
            return (p >= 64'sh8000_0000) ? INT_MIN32 : 32'(-p);
        return (p > 64'sh7FFF_FFFF) ? INT_MAX32 : 32'(p);
    endfunction

    function automatic void set_reg(input mhpg_pkg::cfg_idx_t idx, input logic [19:0] d);
        case (idx)
            mhpg_pkg::REG_SEEK_RPM:     shadow.seek_rpm        = d[17:0];
            mhpg_pkg::REG_BACKOFF_RPM:  shadow.backoff_rpm     = d[17:0];
            mhpg_pkg::REG_BACKOFF_TICK: shadow.backoff_ticks   = d[7:0];
            mhpg_pkg::REG_RPM_GAIN:     shadow.rpm_gain        = d[19:0];
            mhpg_pkg::REG_SPEED_THRESH: shadow.speed_threshold = d[16:0];
            mhpg_pkg::REG_DEADBAND:     shadow.step_deadband   = d[15:0];
            mhpg_pkg::REG_STUCK_LIMIT:  shadow.stuck_limit     = d[19:0];
            mhpg_pkg::REG_LOW_LIMIT:    shadow.low_limit       = d[19:0];
            default: ;
        endcase
    endfunction

    function automatic mhpg_pkg::res_t step_guard(input mhpg_pkg::in_item_t t);
        mhpg_pkg::res_t     r;
        logic [31:0]        cmd;
        bit                 send;
        bit                 homing;
        bit                 stuck;
        bit                 band;
        longint             cmag;
        logic signed [31:0] np;
        logic signed [31:0] tach;
        cmd    = '0;
        send   = 1'b0;
        homing = 1'b1;
        stuck  = 1'b0;
        tach   = $signed(t.tach_count);
        if (t.velocity_valid)
            g_held_vel = $signed(t.velocity_q16);
        case (g_mode)
            mhpg_pkg::MODE_SEEK:
            begin
                send = 1'b1;
                if (t.limit_open)
                begin
                    cmd = 32'($signed(shadow.seek_rpm));
                end
                else
                begin
                    g_backoff_cnt = '0;
                    g_mode        = mhpg_pkg::MODE_BACKOFF;
                end
            end
            mhpg_pkg::MODE_BACKOFF:
            begin
                send = 1'b1;
                if (g_backoff_cnt < shadow.backoff_ticks)
                begin
                    cmd           = 32'($signed(shadow.backoff_rpm));
                    g_backoff_cnt = g_backoff_cnt + 8'd1;
                end
                else
                begin
                    g_settle_tmr = '0;
                    g_prev_a     = -32'sd1;
                    g_prev_b     = -32'sd2;
                    g_mode       = mhpg_pkg::MODE_SETTLE;
                end
            end
            mhpg_pkg::MODE_SETTLE:
            begin
                if (g_settle_tmr != 0)
                begin
                    g_settle_tmr = g_settle_tmr - 3'd1;
                end
                else if (tach == g_prev_a && g_prev_a == g_prev_b)
                begin
                    g_origin   = tach;
                    g_accepted = '0;
                    g_pos      = '0;
                    g_hist1    = '0;
                    g_hist2    = '0;
                    g_range    = 1'b0;
                    g_homed    = 1'b1;
                    g_mode     = mhpg_pkg::MODE_RUN;
                    cmd        = rpm_from_velocity();
                    send       = 1'b1;
                end
                else
                begin
                    g_prev_b     = g_prev_a;
                    g_prev_a     = tach;
                    g_settle_tmr = 3'(SETTLE_TICKS - 1);
                end
            end
            default:
            begin
                if (mag64($signed(t.motor_rpm)) > longint'(shadow.speed_threshold))
                begin
                    np = tach - g_origin;
                    if (mag64(longint'(np) - longint'(g_accepted))
                            > longint'(shadow.step_deadband))
                    begin
                        g_hist2    = g_hist1;
                        g_hist1    = g_accepted;
                        g_pos      = np;
                        g_accepted = np;
                    end
                end
                else
                begin
                    g_hist2 = g_hist1;
                    g_hist1 = g_pos;
                end
                cmag = mag64(g_pos);
                if (cmag > longint'(shadow.stuck_limit))
                    g_range = 1'b1;
                band = cmag > longint'(shadow.stuck_limit) || cmag < longint'(shadow.low_limit);
                if (g_homed && g_range && band && g_pos == g_hist1 && g_pos == g_hist2)
                begin
                    g_backoff_cnt = '0;
                    g_mode        = mhpg_pkg::MODE_SEEK;
                end
                else
                begin
                    homing = 1'b0;
                    stuck  = cmag > longint'(shadow.stuck_limit);
                    if (!stuck)
                    begin
                        cmd  = rpm_from_velocity();
                        send = 1'b1;
                    end
                end
            end
        endcase
        r.rpm_command       = cmd;
        r.send_command      = send;
        r.homing_active     = homing;
        r.position_out      = g_pos;
        r.stuck_flag        = stuck;
        r.velocity_feedback = rpm_from_velocity();
        return r;
    endfunction

    function automatic mhpg_pkg::in_item_t mk_tick(input bit lim, input logic [31:0] rpm,
                                                   input logic [31:0] tach, input bit vv,
                                                   input logic [31:0] vel);
        mhpg_pkg::in_item_t t;
        t.limit_open     = lim;
        t.motor_rpm      = rpm;
        t.tach_count     = tach;
        t.velocity_valid = vv;
        t.velocity_q16   = vel;
        return t;
    endfunction

    function automatic mhpg_pkg::res_t mk_res(input logic [31:0] cmd, input bit send,
                                              input bit homing, input logic [31:0] pos,
                                              input bit stuck, input logic [31:0] fb);
        mhpg_pkg::res_t r;
        r.rpm_command       = cmd;
        r.send_command      = send;
        r.homing_active     = homing;
        r.position_out      = pos;
        r.stuck_flag        = stuck;
        r.velocity_feedback = fb;
        return r;
    endfunction

    function automatic void plan_tick(input mhpg_pkg::in_item_t t, input bit typed = 1'b0,
                                      input mhpg_pkg::res_t want = '0);
        plan_row_t row;
        row.is_reg = 1'b0;
        row.idx    = mhpg_pkg::REG_SEEK_RPM;
        row.value  = '0;
        row.tick   = t;
        row.typed  = typed;
        row.want   = want;
        plan.push_back(row);
    endfunction

    function automatic void plan_reg(input mhpg_pkg::cfg_idx_t idx, input logic [19:0] d);
        plan_row_t row;
        row.is_reg = 1'b1;
        row.idx    = idx;
        row.value  = d;
        row.tick   = '0;
        row.typed  = 1'b0;
        row.want   = '0;
        plan.push_back(row);
    endfunction

    // Draws the next tick from the current mode so that most traffic walks the homing
    // sequence and reaches run mode; a slice of fully random ticks stays as noise.
    function automatic mhpg_pkg::in_item_t draw_tick();
        mhpg_pkg::in_item_t t;
        int                 p;
        int                 span;
        bit                 neg;
        t.limit_open     = 1'b1;
        t.motor_rpm      = $urandom;
        t.tach_count     = $urandom;
        t.velocity_valid = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 4))
            0:       t.velocity_q16 = INT_MAX32;
            1:       t.velocity_q16 = INT_MIN32;
            2:       t.velocity_q16 = $urandom;
            default: t.velocity_q16 = int'($urandom_range(0, 2097152)) - 1048576;
        endcase
        if ($urandom_range(0, 11) == 0)
        begin
            t.limit_open = 1'($urandom_range(0, 1));
            return t;
        end
        neg = 1'($urandom_range(0, 1));
        case (g_mode)
            mhpg_pkg::MODE_SEEK:
            begin
                t.limit_open  = ($urandom_range(0, 3) != 0);
                settle_target = $urandom;
            end
            mhpg_pkg::MODE_BACKOFF: t.limit_open = 1'($urandom_range(0, 1));
            mhpg_pkg::MODE_SETTLE:
            begin
                if ($urandom_range(0, 15) != 0)
                    t.tach_count = settle_target;
            end
            default:
            begin
                t.limit_open = 1'($urandom_range(0, 1));
                span = int'(shadow.speed_threshold);
                if ($urandom_range(0, 9) < 4)
                begin
                    t.motor_rpm = int'($urandom_range(0, 2 * span)) - span;
                end
                else
                begin
                    p = span + 1 + int'($urandom_range(0, 50000));
                    t.motor_rpm = $urandom_range(0, 1) ? -p : p;
                end
                case ($urandom_range(0, 4))
                    0:
                    begin
                        p = $urandom_range(0, shadow.low_limit);
                        p = neg ? -p : p;
                    end
                    1:
                    begin
                        p = int'(shadow.stuck_limit) + 1 + int'($urandom_range(0, 2000));
                        p = neg ? -p : p;
                    end
                    2:
                    begin
                        p = $urandom_range(shadow.low_limit, shadow.stuck_limit);
                        p = neg ? -p : p;
                    end
                    3: p = g_pos;
                    default: p = $urandom;
                endcase
                t.tach_count = g_origin + p;
            end
        endcase
        return t;
    endfunction

    function automatic logic [19:0] phase_setting(input int ph, input mhpg_pkg::cfg_idx_t idx);
        case (ph)
            0: case (idx)
                mhpg_pkg::REG_SEEK_RPM:     return 20'(-3000);
                mhpg_pkg::REG_BACKOFF_RPM:  return 20'(-2000);
                mhpg_pkg::REG_BACKOFF_TICK: return 20'd3;
                mhpg_pkg::REG_RPM_GAIN:     return 20'd100000;
                mhpg_pkg::REG_SPEED_THRESH: return 20'd500;
                mhpg_pkg::REG_DEADBAND:     return 20'd10;
                mhpg_pkg::REG_STUCK_LIMIT:  return 20'd200;
                default:                    return 20'd50;
            endcase
            1: case (idx)
                mhpg_pkg::REG_SEEK_RPM:     return 20'd0;
                mhpg_pkg::REG_BACKOFF_RPM:  return 20'(-100000);
                mhpg_pkg::REG_BACKOFF_TICK: return 20'd255;
                mhpg_pkg::REG_RPM_GAIN:     return 20'hF_FFFF;
                mhpg_pkg::REG_SPEED_THRESH: return 20'd100000;
                mhpg_pkg::REG_DEADBAND:     return 20'd65535;
                mhpg_pkg::REG_STUCK_LIMIT:  return 20'hF_FFFF;
                default:                    return 20'hF_FFFF;
            endcase
            2: case (idx)
                mhpg_pkg::REG_SEEK_RPM:     return 20'(-100000);
                default:                    return 20'd0;
            endcase
            default: case (idx)
                mhpg_pkg::REG_SEEK_RPM:     return 20'(-int'($urandom_range(0, 100000)));
                mhpg_pkg::REG_BACKOFF_RPM:  return 20'(-int'($urandom_range(0, 100000)));
                mhpg_pkg::REG_BACKOFF_TICK: return 20'($urandom_range(0, 6));
                mhpg_pkg::REG_RPM_GAIN:     return 20'($urandom_range(0, 1048575));
                mhpg_pkg::REG_SPEED_THRESH: return 20'($urandom_range(0, 2000));
                mhpg_pkg::REG_DEADBAND:     return 20'($urandom_range(0, 300));
                mhpg_pkg::REG_STUCK_LIMIT:  return 20'($urandom_range(100, 5000));
                default:                    return 20'($urandom_range(0, 5000));
            endcase
        endcase
    endfunction

    // Each operation starts at a falling edge; a tick returns at the rising edge
    // where it was taken, so its valid may stay high into the next tick.
    task automatic send_tick(input mhpg_pkg::in_item_t t, input bit typed,
                             input mhpg_pkg::res_t want);
        mhpg_pkg::res_t predicted;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        s_tdata  <= {7'd0, t.velocity_q16, t.tach_count, t.motor_rpm, t.limit_open};
        s_tuser  <= t.velocity_valid;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        predicted = step_guard(t);
        outputs_due.push_back(typed ? want : predicted);
    endtask

    task automatic write_reg(input mhpg_pkg::cfg_idx_t idx, input logic [19:0] d);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outputs_due.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        set_reg(idx, d);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random back-pressure plus one long hold-off
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        mhpg_pkg::res_t want;
        mhpg_pkg::res_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.rpm_command       = m_tdata[31:0];
            got.homing_active     = m_tdata[32];
            got.position_out      = m_tdata[64:33];
            got.stuck_flag        = m_tdata[65];
            got.velocity_feedback = m_tdata[97:66];
            got.send_command      = m_tuser[0];
            if (outputs_due.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("result %0d: transaction with nothing outstanding", result_count);
            end
            else
            begin
                want = outputs_due.pop_front();
                if (got.rpm_command !== want.rpm_command
                        || got.send_command !== want.send_command
                        || got.homing_active !== want.homing_active
                        || got.position_out !== want.position_out
                        || got.stuck_flag !== want.stuck_flag
                        || got.velocity_feedback !== want.velocity_feedback)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $display("result %0d: exp cmd=%0d send=%0b home=%0b pos=%0d stuck=%0b fb=%0d",
                                 result_count,
                                 $signed(want.rpm_command), want.send_command,
                                 want.homing_active, $signed(want.position_out),
                                 want.stuck_flag, $signed(want.velocity_feedback));
                        $display("result %0d: got cmd=%0d send=%0b home=%0b pos=%0d stuck=%0b fb=%0d",
                                 result_count,
                                 $signed(got.rpm_command), got.send_command,
                                 got.homing_active, $signed(got.position_out),
                                 got.stuck_flag, $signed(got.velocity_feedback));
                    end
                end
            end
            result_count++;
        end
    end

    initial
    begin
        int phase_len[4];
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = mhpg_pkg::REG_SEEK_RPM;
        cfg_data  = '0;
        phase_len = '{50, 300, 40, 40};

        // reset defaults, velocity saturation both ways, truncation toward zero
        plan_tick(mk_tick(1'b1, 0, 0, 1'b0, 0), 1'b1,
                  mk_res(-32'sd2500, 1'b1, 1'b1, 0, 1'b0, 0));
        plan_tick(mk_tick(1'b1, INT_MAX32, INT_MAX32, 1'b1, INT_MAX32), 1'b1,
                  mk_res(-32'sd2500, 1'b1, 1'b1, 0, 1'b0, INT_MAX32));
        plan_tick(mk_tick(1'b1, INT_MIN32, INT_MIN32, 1'b1, INT_MIN32), 1'b1,
                  mk_res(-32'sd2500, 1'b1, 1'b1, 0, 1'b0, INT_MIN32));
        plan_tick(mk_tick(1'b1, 0, 0, 1'b1, 32'hFFFF_FFFF), 1'b1,
                  mk_res(-32'sd2500, 1'b1, 1'b1, 0, 1'b0, 32'hFFFF_FFFF));
        plan_tick(mk_tick(1'b0, 0, 0, 1'b0, 0), 1'b1,
                  mk_res(0, 1'b1, 1'b1, 0, 1'b0, 32'hFFFF_FFFF));
        plan_reg(mhpg_pkg::REG_BACKOFF_TICK, 20'd1);
        plan_tick(mk_tick(1'b1, 0, 0, 1'b0, 0), 1'b1,
                  mk_res(-32'sd2300, 1'b1, 1'b1, 0, 1'b0, 32'hFFFF_FFFF));
        plan_tick(mk_tick(1'b0, 0, 0, 1'b0, 0));
        // three equal samples SETTLE_TICKS apart give the origin
        plan_tick(mk_tick(1'b1, 0, HOME_TACH, 1'b1, 32'h0001_0000));
        repeat (9) plan_tick(mk_tick(1'b1, 0, HOME_TACH, 1'b0, 0));
        plan_tick(mk_tick(1'b1, 0, HOME_TACH, 1'b0, 0), 1'b1,
                  mk_res(32'd100000, 1'b1, 1'b1, 0, 1'b0, 32'd100000));
        // leave the band, a step inside the deadband, then stall until re-home
        plan_tick(mk_tick(1'b1, 32'd1000, HOME_TACH + 32'd300, 1'b0, 0));
        plan_tick(mk_tick(1'b1, 32'd1000, HOME_TACH + 32'd305, 1'b0, 0));
        plan_tick(mk_tick(1'b1, 0, HOME_TACH + 32'd305, 1'b0, 0));
        plan_tick(mk_tick(1'b1, 0, HOME_TACH, 1'b0, 0), 1'b1,
                  mk_res(0, 1'b0, 1'b1, 32'd300, 1'b0, 32'd100000));
        plan_tick(mk_tick(1'b1, INT_MIN32, 0, 1'b0, 0));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_reg)
                write_reg(plan[i].idx, plan[i].value);
            else
                send_tick(plan[i].tick, plan[i].typed, plan[i].want);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            for (int k = 0; k < 8; k++)
                write_reg(mhpg_pkg::cfg_idx_t'(k), phase_setting(ph, mhpg_pkg::cfg_idx_t'(k)));
            if (ph == 1)
                hold_req = 1'b1;
            for (int n = 0; n < phase_len[ph]; n++)
            begin
                if (ph == 3 && n >= phase_len[ph] / 2)
                    quiet = 1'b1;
                send_tick(draw_tick(), 1'b0, '0);
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outputs_due.size() != 0) @(posedge clk);
        repeat (2 * DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
